// File: rtl/core/bmfgp_pkg.sv
// Shared types, codes and constants of the binary bitmap-font glyph parser.
`default_nettype none

package bmfgp_pkg;

    // Configuration register indexes.
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_FILE_LENGTH = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_ID_LIMIT    = 1'd1;
    localparam int CfgDataW = 32;

    localparam logic [8:0] ID_LIMIT_RESET = 9'd128;
    localparam logic [8:0] ID_LIMIT_MAX   = 9'd256;

    // Parser phases.
    localparam logic [2:0] PH_MAGIC = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    // Page-name scan states.
    localparam logic [1:0] NS_START  = 2'd0;
    localparam logic [1:0] NS_INSIDE = 2'd1;
    localparam logic [1:0] NS_ENDED  = 2'd2;

    // Block types.
    localparam logic [7:0] BLK_COMMON = 8'd2;
    localparam logic [7:0] BLK_PAGES  = 8'd3;
    localparam logic [7:0] BLK_CHARS  = 8'd4;

    // Result kinds.
    localparam logic [2:0] KIND_GLYPH   = 3'd0;
    localparam logic [2:0] KIND_LINE    = 3'd1;
    localparam logic [2:0] KIND_DONE_OK = 3'd2;
    localparam logic [2:0] KIND_BAD_MAG = 3'd3;
    localparam logic [2:0] KIND_NO_DATA = 3'd4;

    // A chars record is 20 bytes; the first 19 are stored, the last one closes it.
    localparam int RecStored = 19;
    localparam logic [4:0] REC_LAST = 5'd19;

    // Result queue geometry (depth is a power of two).
    localparam int QueueAw   = 2;
    localparam int QueueDepth = 1 << QueueAw;
    localparam int QueueCntW = QueueAw + 1;

    localparam int PayloadW = 144;

    // Result payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [15:0] line_height;
        logic [7:0]  page_index;
        logic [15:0] pen_advance;
        logic [15:0] draw_offset_y;
        logic [15:0] draw_offset_x;
        logic [15:0] glyph_height;
        logic [15:0] glyph_width;
        logic [15:0] atlas_y;
        logic [15:0] atlas_x;
        logic [7:0]  glyph_id;
    } payload_t;

    // What one input byte produced: an optional data result and an optional status.
    typedef struct packed {
        logic       has_data;
        logic [2:0] data_kind;
        payload_t   payload;
        logic       has_status;
        logic [2:0] status_kind;
    } entry_t;

    // Expected file signature, byte by byte.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0: val = 8'h42;
            2'd1: val = 8'h4D;
            2'd2: val = 8'h46;
            default: val = 8'h03;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bmfgp_queue.sv
// Short register queue of parse results between the front and back parts.
`default_nettype none

module bmfgp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire bmfgp_pkg::entry_t push_entry,
    output logic                   full,
    input  wire logic              pop,
    output bmfgp_pkg::entry_t      pop_entry,
    output logic                   empty
);

    bmfgp_pkg::entry_t mem_reg [0:bmfgp_pkg::QueueDepth-1];
    logic [bmfgp_pkg::QueueAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bmfgp_pkg::QueueAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bmfgp_pkg::QueueCntW-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full      = (count_reg == bmfgp_pkg::QueueCntW'(bmfgp_pkg::QueueDepth));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bmfgp_front.sv
// Front part: takes file bytes, tracks the block structure and builds results.
`default_nettype none

module bmfgp_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bmfgp_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [bmfgp_pkg::CfgDataW-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output bmfgp_pkg::entry_t                     q_entry
);

    logic [31:0] file_length_reg;
    logic [8:0]  id_limit_reg;

    logic [31:0] byte_offset_reg, byte_offset_next;
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  fbc_reg, fbc_next;
    logic [7:0]  block_kind_reg, block_kind_next;
    logic [31:0] block_length_reg, block_length_next;
    logic [31:0] body_pos_reg, body_pos_next;
    logic [7:0]  lh_low_reg, lh_low_next;
    logic [1:0]  name_state_reg, name_state_next;
    logic        seen_page_reg, seen_page_next;
    logic        seen_glyph_reg, seen_glyph_next;
    logic        magic_failed_reg, magic_failed_next;

    logic [7:0]  rec_reg [0:bmfgp_pkg::RecStored-1];
    logic        rec_we;

    logic        accept;
    logic        byte_go;
    logic        is_last;
    logic        hdr_over;
    logic [31:0] new_len;
    logic        len_over;
    logic [31:0] pos_p1;
    logic        id_ok;
    logic [8:0]  lim_eff;
    logic [8:0]  id_low;
    bmfgp_pkg::entry_t entry;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign byte_go  = accept && (byte_offset_reg < file_length_reg);

    // Position checks against the file end.
    assign is_last  = ({1'b0, byte_offset_reg} + 33'd1) == {1'b0, file_length_reg};
    assign hdr_over = ({1'b0, byte_offset_reg} + 33'd5) > {1'b0, file_length_reg};
    assign new_len  = block_length_reg | ({24'd0, s_tdata} << {fbc_reg[1:0], 3'b000});
    assign len_over = ({2'b00, byte_offset_reg} + {2'b00, new_len} + 34'd1)
                      > {2'b00, file_length_reg};
    assign pos_p1   = body_pos_reg + 32'd1;

    // Glyph id test: the id must be below the limit, which tops out at 256.
    assign lim_eff = (id_limit_reg > bmfgp_pkg::ID_LIMIT_MAX) ?
                     bmfgp_pkg::ID_LIMIT_MAX : id_limit_reg;
    assign id_low  = {rec_reg[1][0], rec_reg[0]};
    assign id_ok   = (rec_reg[3] == 8'd0) && (rec_reg[2] == 8'd0) &&
                     (rec_reg[1][7:1] == 7'd0) && (id_low < lim_eff);

    // Parser state update and result assembly.
    always_comb begin
        byte_offset_next  = byte_offset_reg;
        phase_next        = phase_reg;
        fbc_next          = fbc_reg;
        block_kind_next   = block_kind_reg;
        block_length_next = block_length_reg;
        body_pos_next     = body_pos_reg;
        lh_low_next       = lh_low_reg;
        name_state_next   = name_state_reg;
        seen_page_next    = seen_page_reg;
        seen_glyph_next   = seen_glyph_reg;
        magic_failed_next = magic_failed_reg;
        rec_we            = 1'b0;
        entry             = '0;

        if (byte_go) begin
            if (byte_offset_reg != 32'hFFFF_FFFF) begin
                byte_offset_next = byte_offset_reg + 32'd1;
            end

            case (phase_reg)
                bmfgp_pkg::PH_MAGIC: begin
                    if (s_tdata != bmfgp_pkg::magic_byte(fbc_reg[1:0])) begin
                        magic_failed_next = 1'b1;
                    end
                    if (fbc_reg >= 5'd3) begin
                        fbc_next   = 5'd0;
                        phase_next = magic_failed_next ? bmfgp_pkg::PH_STOP
                                                       : bmfgp_pkg::PH_TYPE;
                    end else begin
                        fbc_next = fbc_reg + 5'd1;
                    end
                end
                bmfgp_pkg::PH_TYPE: begin
                    if (hdr_over) begin
                        phase_next = bmfgp_pkg::PH_STOP;
                    end else begin
                        block_kind_next   = s_tdata;
                        block_length_next = 32'd0;
                        fbc_next          = 5'd0;
                        phase_next        = bmfgp_pkg::PH_LEN;
                    end
                end
                bmfgp_pkg::PH_LEN: begin
                    block_length_next = new_len;
                    if (fbc_reg >= 5'd3) begin
                        fbc_next        = 5'd0;
                        body_pos_next   = 32'd0;
                        name_state_next = bmfgp_pkg::NS_START;
                        if (len_over) begin
                            phase_next = bmfgp_pkg::PH_STOP;
                        end else if (new_len == 32'd0) begin
                            phase_next = bmfgp_pkg::PH_TYPE;
                        end else begin
                            phase_next = bmfgp_pkg::PH_BODY;
                        end
                    end else begin
                        fbc_next = fbc_reg + 5'd1;
                    end
                end
                bmfgp_pkg::PH_BODY: begin
                    case (block_kind_reg)
                        bmfgp_pkg::BLK_COMMON: begin
                            if (body_pos_reg == 32'd0) begin
                                lh_low_next = s_tdata;
                            end else if (body_pos_reg == 32'd1) begin
                                entry.has_data            = 1'b1;
                                entry.data_kind           = bmfgp_pkg::KIND_LINE;
                                entry.payload.line_height = {s_tdata, lh_low_reg};
                            end
                        end
                        bmfgp_pkg::BLK_PAGES: begin
                            if (name_state_reg == bmfgp_pkg::NS_START) begin
                                if (s_tdata != 8'd0) begin
                                    seen_page_next  = 1'b1;
                                    name_state_next = bmfgp_pkg::NS_INSIDE;
                                end else begin
                                    name_state_next = bmfgp_pkg::NS_ENDED;
                                end
                            end else if (name_state_reg == bmfgp_pkg::NS_INSIDE) begin
                                if (s_tdata == 8'd0) begin
                                    name_state_next = bmfgp_pkg::NS_START;
                                end
                            end
                        end
                        bmfgp_pkg::BLK_CHARS: begin
                            if (fbc_reg < bmfgp_pkg::REC_LAST) begin
                                rec_we   = 1'b1;
                                fbc_next = fbc_reg + 5'd1;
                            end else begin
                                fbc_next = 5'd0;
                                if (id_ok) begin
                                    seen_glyph_next             = 1'b1;
                                    entry.has_data              = 1'b1;
                                    entry.data_kind             = bmfgp_pkg::KIND_GLYPH;
                                    entry.payload.glyph_id      = rec_reg[0];
                                    entry.payload.atlas_x       = {rec_reg[5], rec_reg[4]};
                                    entry.payload.atlas_y       = {rec_reg[7], rec_reg[6]};
                                    entry.payload.glyph_width   = {rec_reg[9], rec_reg[8]};
                                    entry.payload.glyph_height  = {rec_reg[11], rec_reg[10]};
                                    entry.payload.draw_offset_x = {rec_reg[13], rec_reg[12]};
                                    entry.payload.draw_offset_y = {rec_reg[15], rec_reg[14]};
                                    entry.payload.pen_advance   = {rec_reg[17], rec_reg[16]};
                                    entry.payload.page_index    = rec_reg[18];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    body_pos_next = pos_p1;
                    if (pos_p1 >= block_length_reg) begin
                        phase_next = bmfgp_pkg::PH_TYPE;
                    end
                end
                default: begin
                end
            endcase

            // The final byte of the file also reports the overall status.
            if (is_last) begin
                entry.has_status = 1'b1;
                if (magic_failed_next || (byte_offset_reg < 32'd3)) begin
                    entry.status_kind = bmfgp_pkg::KIND_BAD_MAG;
                end else if (seen_glyph_next && seen_page_next) begin
                    entry.status_kind = bmfgp_pkg::KIND_DONE_OK;
                end else begin
                    entry.status_kind = bmfgp_pkg::KIND_NO_DATA;
                end
            end
        end
    end

    assign q_push  = entry.has_data || entry.has_status;
    assign q_entry = entry;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= 32'd0;
            id_limit_reg    <= bmfgp_pkg::ID_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                bmfgp_pkg::CFG_FILE_LENGTH: file_length_reg <= cfg_wdata;
                bmfgp_pkg::CFG_ID_LIMIT:    id_limit_reg    <= cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg  <= 32'd0;
            phase_reg        <= bmfgp_pkg::PH_MAGIC;
            fbc_reg          <= 5'd0;
            block_kind_reg   <= 8'd0;
            block_length_reg <= 32'd0;
            body_pos_reg     <= 32'd0;
            lh_low_reg       <= 8'd0;
            name_state_reg   <= bmfgp_pkg::NS_START;
            seen_page_reg    <= 1'b0;
            seen_glyph_reg   <= 1'b0;
            magic_failed_reg <= 1'b0;
        end else begin
            byte_offset_reg  <= byte_offset_next;
            phase_reg        <= phase_next;
            fbc_reg          <= fbc_next;
            block_kind_reg   <= block_kind_next;
            block_length_reg <= block_length_next;
            body_pos_reg     <= body_pos_next;
            lh_low_reg       <= lh_low_next;
            name_state_reg   <= name_state_next;
            seen_page_reg    <= seen_page_next;
            seen_glyph_reg   <= seen_glyph_next;
            magic_failed_reg <= magic_failed_next;
        end
    end

    // Record byte store of the chars block.
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_reg[fbc_reg] <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bmfgp_back.sv
// Back part: drains queued results into the output register, one word per cycle while the receiver is ready.
`default_nettype none

module bmfgp_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire bmfgp_pkg::entry_t               q_entry,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bmfgp_pkg::PayloadW-1:0]       m_tdata,
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast
);

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [bmfgp_pkg::PayloadW-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]                    m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic                          pend_reg, pend_next;
    logic [2:0]                    pend_kind_reg, pend_kind_next;
    logic                          load_ok;

    assign load_ok = !m_tvalid_reg || m_tready;

    // A held status word goes out before the next queue entry is taken.
    always_comb begin
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        q_pop          = 1'b0;
        if (load_ok) begin
            if (pend_reg) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tuser_next  = pend_kind_reg;
                m_tlast_next  = 1'b1;
                pend_next     = 1'b0;
            end else if (!q_empty) begin
                q_pop         = 1'b1;
                m_tvalid_next = 1'b1;
                if (q_entry.has_data) begin
                    m_tdata_next   = q_entry.payload;
                    m_tuser_next   = q_entry.data_kind;
                    m_tlast_next   = !q_entry.has_status;
                    pend_next      = q_entry.has_status;
                    pend_kind_next = q_entry.status_kind;
                end else begin
                    m_tdata_next = '0;
                    m_tuser_next = q_entry.status_kind;
                    m_tlast_next = 1'b1;
                end
            end else begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
        pend_kind_reg <= pend_kind_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: rtl/core/bmfont_binary_glyph_parser.sv
// Top level of the binary bitmap-font glyph parser.
//
//   Channel   Direction  Word                      Handshake
//   s_*       in         one file byte             s_tvalid / s_tready
//   m_*       out        one result                m_tvalid / m_tready
//   cfg_*     in         register write            cfg_we (no wait)
//
// One byte is taken per cycle while the queue has room; the front part finishes each byte in that cycle.
// Results pass through a four-entry queue and a registered output stage, so the
// input stalls only when the queue is full. The last byte of a file may produce
// two results, which leave back to back while the receiver is ready.
// Reset is synchronous and active low; it clears the parser, queue and output.
`default_nettype none

module bmfont_binary_glyph_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bmfgp_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [bmfgp_pkg::CfgDataW-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,    // data_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // glyph_id, atlas_x, atlas_y, glyph_width, glyph_height, draw_offset_x,
    // draw_offset_y, pen_advance, page_index, line_height
    output logic [bmfgp_pkg::PayloadW-1:0]        m_tdata,
    output logic [2:0]                            m_tuser,    // kind
    output logic                                  m_tlast     // end_of_run
);

    bmfgp_pkg::entry_t push_entry;
    bmfgp_pkg::entry_t pop_entry;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    bmfgp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    bmfgp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    bmfgp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
